/* rtl/sitdt_pkg.sv */
// shared types and constants for the signed integer to decimal text converter
package sitdt_pkg;

  localparam int NUM_DIGITS     = 10;
  localparam int BCD_W          = 4 * NUM_DIGITS;
  localparam int VALUE_W        = 32;
  localparam int BIN_W          = 33;
  localparam int STEPS_PER_CYC  = 3;
  localparam int CONV_CYCLES    = BIN_W / STEPS_PER_CYC;
  localparam int CNT_W          = 4;
  localparam int CHAR_W         = 7;

  localparam logic [CHAR_W-1:0] CH_MINUS = 7'd45;
  localparam logic [CHAR_W-1:0] CH_ZERO  = 7'd48;

  typedef struct packed {
    logic             neg;
    logic [CNT_W-1:0] ndig;
    logic [BCD_W-1:0] bcd;
  } conv_t;

endpackage

/* rtl/sitdt_front.sv */
// front end: accepts a value, takes its magnitude and converts it to bcd
module sitdt_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic signed [31:0]    value,
  output logic                  push_valid,
  input  logic                  push_ready,
  output sitdt_pkg::conv_t      push_data
);
  import sitdt_pkg::*;

  typedef enum logic [1:0] {S_IDLE, S_CONV, S_DONE} state_t;

  state_t             state;
  logic               neg;
  logic [BIN_W-1:0]   bin;
  logic [BCD_W-1:0]   bcd;
  logic [CNT_W-1:0]   cnt;

  logic [BIN_W-1:0]   bin_next;
  logic [BCD_W-1:0]   bcd_next;
  logic [VALUE_W-1:0] mag;
  logic [CNT_W-1:0]   ndig;
  logic               accept;

  // three shift-and-add-3 steps per cycle
  always_comb begin
    logic [BCD_W+BIN_W-1:0] acc;
    acc = {bcd, bin};
    for (int s = 0; s < STEPS_PER_CYC; s++) begin
      for (int d = 0; d < NUM_DIGITS; d++) begin
        if (acc[BIN_W+4*d +: 4] >= 4'd5) begin
          acc[BIN_W+4*d +: 4] = acc[BIN_W+4*d +: 4] + 4'd3;
        end
      end
      acc = acc << 1;
    end
    bcd_next = acc[BCD_W+BIN_W-1:BIN_W];
    bin_next = acc[BIN_W-1:0];
  end

  // digit count from the highest nonzero digit
  always_comb begin
    ndig = CNT_W'(1);
    for (int d = 0; d < NUM_DIGITS; d++) begin
      if (bcd[4*d +: 4] != 4'd0) begin
        ndig = CNT_W'(d + 1);
      end
    end
  end

  assign mag        = value[31] ? (~$unsigned(value) + 32'd1) : $unsigned(value);
  assign push_valid = (state == S_DONE);
  assign push_data  = '{neg: neg, ndig: ndig, bcd: bcd};
  assign in_ready   = (state == S_IDLE) || ((state == S_DONE) && push_ready);
  assign accept     = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            state <= S_CONV;
          end
        end
        S_CONV: begin
          cnt <= cnt + CNT_W'(1);
          if (cnt == CNT_W'(CONV_CYCLES - 1)) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (push_ready) begin
            state <= accept ? S_CONV : S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
      if (accept) begin
        cnt <= '0;
      end
    end
    if (accept) begin
      neg <= value[31];
      bin <= {1'b0, mag};
      bcd <= '0;
    end else if (state == S_CONV) begin
      bin <= bin_next;
      bcd <= bcd_next;
    end
  end

endmodule

/* rtl/sitdt_queue.sv */
// short request queue between the converter and the character sequencer
module sitdt_queue #(
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push_valid,
  output logic             push_ready,
  input  sitdt_pkg::conv_t push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output sitdt_pkg::conv_t pop_data
);
  import sitdt_pkg::*;

  localparam int PTR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int COUNT_W = $clog2(DEPTH + 1);

  conv_t              entries [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [COUNT_W-1:0] count;
  logic               do_push;
  logic               do_pop;

  assign push_ready = (count != COUNT_W'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = entries[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + COUNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - COUNT_W'(1);
      end
    end
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule

/* rtl/sitdt_back.sv */
// back end: emits the sign and digits of one request, one character a cycle while out_ready is high
module sitdt_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             pop_valid,
  output logic             pop_ready,
  input  sitdt_pkg::conv_t pop_data,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [6:0]       char_code,
  output logic [3:0]       char_pos,
  output logic [3:0]       text_length,
  output logic             is_last
);
  import sitdt_pkg::*;

  logic             busy;
  conv_t            cur;
  logic [CNT_W-1:0] pos;

  logic [3:0]       digits [NUM_DIGITS];
  logic [CNT_W-1:0] len;
  logic [CNT_W-1:0] nib;
  logic             load;
  logic             fire;

  always_comb begin
    for (int d = 0; d < NUM_DIGITS; d++) begin
      digits[d] = cur.bcd[4*d +: 4];
    end
  end

  assign len         = cur.ndig + CNT_W'(cur.neg);
  assign nib         = cur.ndig - CNT_W'(1) - (pos - CNT_W'(cur.neg));
  assign out_valid   = busy;
  assign char_pos    = pos;
  assign text_length = len;
  assign is_last     = (pos == len - CNT_W'(1));
  assign char_code   = (cur.neg && pos == '0) ? CH_MINUS : CH_ZERO + {3'b000, digits[nib]};
  assign fire        = out_valid && out_ready;
  assign pop_ready   = !busy || (fire && is_last);
  assign load        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      pos  <= '0;
    end else begin
      if (load) begin
        busy <= 1'b1;
        pos  <= '0;
      end else if (fire) begin
        if (is_last) begin
          busy <= 1'b0;
        end
        pos <= pos + CNT_W'(1);
      end
    end
    if (load) begin
      cur <= pop_data;
    end
  end

endmodule

/* rtl/signed_int_to_decimal_text.sv */
// top level: signed 32-bit integer to decimal ascii text
//
//   channel  handshake            payload
//   in       in_valid / in_ready  value
//   out      out_valid/out_ready  char_code, char_pos, text_length, is_last
//
// the front converts one value in its S_CONV state (three double-dabble steps per cycle),
// then holds it in S_DONE until the queue takes it; a new value is taken as it hands off.
// the back emits one character per cycle while out_ready is high, 1 to 11 per value, from its own registers.
// the queue lets the front start the next value while the back is still emitting.
// rst is synchronous and clears all control state; no clearing pass is needed.
module signed_int_to_decimal_text #(
  parameter int QUEUE_DEPTH = 2
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [6:0]         char_code,
  output logic [3:0]         char_pos,
  output logic [3:0]         text_length,
  output logic               is_last
);
  import sitdt_pkg::*;

  logic  push_valid;
  logic  push_ready;
  conv_t push_data;
  logic  pop_valid;
  logic  pop_ready;
  conv_t pop_data;

  sitdt_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .value      (value),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  sitdt_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  sitdt_back u_back (
    .clk         (clk),
    .rst         (rst),
    .pop_valid   (pop_valid),
    .pop_ready   (pop_ready),
    .pop_data    (pop_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .char_code   (char_code),
    .char_pos    (char_pos),
    .text_length (text_length),
    .is_last     (is_last)
  );

endmodule
